// ===== sv/rtt_sign_sketch_assert.svh =====
// Assertion shorthands for the sketch block; clock clk, reset arst_n.
`ifndef RTT_SIGN_SKETCH_ASSERT_SVH
`define RTT_SIGN_SKETCH_ASSERT_SVH

// Same-cycle implication
`define RTT_SK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define RTT_SK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rtt_sk_pkg.sv =====
package rtt_sk_pkg;

	// Geometry defaults
	localparam int unsigned ROWS_DEF    = 3;
	localparam int unsigned COLUMNS_DEF = 4096;

	// Field widths
	localparam int unsigned KEY_W  = 32;
	localparam int unsigned TS_W   = 31;
	localparam int unsigned CNT_W  = 32;
	localparam int unsigned CELL_W = 2 * CNT_W;
	localparam int unsigned SEED_SETS = 3;

	// APB
	localparam int unsigned APB_DW  = 32;
	localparam int unsigned PADDR_W = 5;

	// Request codes
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// Register map
	typedef enum logic [2:0] {
		REG_GAP_TIMEOUT  = 3'd0,
		REG_INDEX_SEED_0 = 3'd1,
		REG_INDEX_SEED_1 = 3'd2,
		REG_INDEX_SEED_2 = 3'd3,
		REG_SIGN_SEED_0  = 3'd4,
		REG_SIGN_SEED_1  = 3'd5,
		REG_SIGN_SEED_2  = 3'd6
	} reg_idx_t;

	// Register reset values
	localparam logic [TS_W-1:0]  GAP_TIMEOUT_RST = 31'd1000000;
	localparam logic [31:0]      INDEX_SEED_RST [SEED_SETS] = '{32'd1, 32'd2, 32'd3};
	localparam logic [31:0]      SIGN_SEED_RST  [SEED_SETS] = '{32'd4, 32'd5, 32'd6};

	// Hash constants (32-bit MurmurHash3, one 4-byte block)
	localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
	localparam logic [31:0] MM_C2   = 32'h1b873593;
	localparam logic [31:0] MM_C3   = 32'h85ebca6b;
	localparam logic [31:0] MM_C4   = 32'hc2b2ae35;
	localparam logic [31:0] MM_ADD  = 32'he6546b64;
	localparam logic [31:0] MM_LEN  = 32'd4;

	function automatic logic [31:0] rotl15(input logic [31:0] x);
		return {x[16:0], x[31:17]};
	endfunction

	// Block mix: seed xor k, rotate, times 5 plus constant, then length fold
	function automatic logic [31:0] mm_head(input logic [31:0] seed, input logic [31:0] k);
		logic [31:0] h;
		h = seed ^ k;
		h = {h[18:0], h[31:19]};
		h = (h << 2) + h + MM_ADD;
		return h ^ MM_LEN;
	endfunction

endpackage

// ===== sv/rtt_sk_if.sv =====
interface rtt_sk_req_if;
	import rtt_sk_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [KEY_W-1:0]  flow_key;
	logic              forward_dir;
	logic [TS_W-1:0]   timestamp;
	modport source (output valid, req_type, flow_key, forward_dir, timestamp, input ready);
	modport sink   (input valid, req_type, flow_key, forward_dir, timestamp, output ready);
endinterface

interface rtt_sk_res_if;
	import rtt_sk_pkg::*;
	logic             valid;
	logic             ready;
	logic [TS_W-1:0]  rtt_estimate;
	modport source (output valid, rtt_estimate, input ready);
	modport sink   (input valid, rtt_estimate, output ready);
endinterface

// ===== sv/rtt_sign_sketch.sv =====
// Channel   Dir  Payload                                        Handshake
// req       in   req_type, flow_key, forward_dir, timestamp     valid/ready
// res       out  rtt_estimate (one per query, none per insert)  valid/ready
// apb       in   psel/penable/pwrite/paddr/pwdata -> prdata     pready tied high
//
// One request at a time. An insert runs the key states KEY1 and KEY2, then for each row
// the hash states ROW1..ROW4, the column remainder states MOD1..MOD3 (reciprocal multiply,
// back-multiply, compare and subtract) and the cell memory states READ and WRITE. A query
// then adds median ranking (MED) and result load (OUT). After reset the cell memory is
// swept to zero, req.ready low. A waiting result does not block the next request; only
// a second query stalls at its result load until res is free.
module rtt_sign_sketch #(
	parameter int unsigned ROWS    = rtt_sk_pkg::ROWS_DEF,
	parameter int unsigned COLUMNS = rtt_sk_pkg::COLUMNS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rtt_sk_pkg::PADDR_W-1:0]  paddr,
	input  logic [rtt_sk_pkg::APB_DW-1:0]   pwdata,
	output logic [rtt_sk_pkg::APB_DW-1:0]   prdata,
	output logic                            pready,
	rtt_sk_req_if.sink                      req,
	rtt_sk_res_if.source                    res
);
	import rtt_sk_pkg::*;

	`include "rtt_sign_sketch_assert.svh"

	localparam int unsigned CELLS = ROWS * COLUMNS;
	localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int unsigned CW    = $clog2(COLUMNS);
	localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	// floor(2^32 / COLUMNS): quotient estimate low by at most one
	localparam logic [31:0] MOD_MUL = 32'((64'd1 << 32) / 64'(COLUMNS));

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_KEY1, ST_KEY2, ST_ROW1, ST_ROW2, ST_ROW3, ST_ROW4,
		ST_MOD1, ST_MOD2, ST_MOD3, ST_READ, ST_WRITE, ST_MED, ST_OUT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [TS_W-1:0] gap_timeout_q;
	logic [31:0]     index_seed_q [SEED_SETS];
	logic [31:0]     sign_seed_q  [SEED_SETS];
	reg_idx_t        reg_idx;
	logic            cfg_we;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_we  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_timeout_q <= GAP_TIMEOUT_RST;
			for (int i = 0; i < SEED_SETS; i++) begin
				index_seed_q[i] <= INDEX_SEED_RST[i];
				sign_seed_q[i]  <= SIGN_SEED_RST[i];
			end
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_GAP_TIMEOUT:  gap_timeout_q   <= pwdata[TS_W-1:0];
				REG_INDEX_SEED_0: index_seed_q[0] <= pwdata;
				REG_INDEX_SEED_1: index_seed_q[1] <= pwdata;
				REG_INDEX_SEED_2: index_seed_q[2] <= pwdata;
				REG_SIGN_SEED_0:  sign_seed_q[0]  <= pwdata;
				REG_SIGN_SEED_1:  sign_seed_q[1]  <= pwdata;
				REG_SIGN_SEED_2:  sign_seed_q[2]  <= pwdata;
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_idx)
			REG_GAP_TIMEOUT:  prdata = {1'b0, gap_timeout_q};
			REG_INDEX_SEED_0: prdata = index_seed_q[0];
			REG_INDEX_SEED_1: prdata = index_seed_q[1];
			REG_INDEX_SEED_2: prdata = index_seed_q[2];
			REG_SIGN_SEED_0:  prdata = sign_seed_q[0];
			REG_SIGN_SEED_1:  prdata = sign_seed_q[1];
			REG_SIGN_SEED_2:  prdata = sign_seed_q[2];
			default:          prdata = '0;
		endcase
	end

	// Request and datapath registers
	logic             req_q;
	logic [KEY_W-1:0] key_q;
	logic             fwd_q;
	logic [TS_W-1:0]  ts_q;
	logic [31:0]      k_q;
	logic [31:0]      hi_q, hs_q;
	logic [31:0]      quo_q;
	logic             add_q;
	logic [CW-1:0]    rem_q;
	logic [RW-1:0]    row_q;
	logic [1:0]       sel_q;
	logic [RW-1:0]    off_q;
	logic [AW-1:0]    base_q;
	logic [AW-1:0]    clr_q;
	logic [RW-1:0]    med_i_q;
	logic [CNT_W-1:0] vals_q [ROWS];
	logic [CNT_W-1:0] med_q;
	logic             res_valid_q;
	logic [TS_W-1:0]  res_est_q;

	assign req.ready        = (state_q == ST_IDLE);
	assign res.valid        = res_valid_q;
	assign res.rtt_estimate = res_est_q;

	logic accept;
	logic last_row;
	assign accept   = req.valid && (state_q == ST_IDLE);
	assign last_row = (row_q == RW'(ROWS - 1));

	// Column remainder: reciprocal product gives the quotient estimate
	logic [63:0] mod_prod;
	assign mod_prod = {32'd0, hi_q} * {32'd0, MOD_MUL};

	// Cell memory: {last_seen, rtt_counter}
	logic [CELL_W-1:0] cell_mem [CELLS];
	logic [CELL_W-1:0] rdata_q;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;

	assign mem_re    = (state_q == ST_READ);
	assign mem_raddr = base_q + AW'(rem_q);

	always_ff @(posedge clk) begin
		if (mem_we)
			cell_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= cell_mem[mem_raddr];
	end

	// Cell update for an insert, signed view for a query
	logic [CNT_W-1:0] new_last, new_cnt, qval;
	always_comb begin
		logic [CNT_W-1:0] stored, cnt;
		logic [32:0]      t33, st33, gap;
		logic             has, take;
		stored = rdata_q[CELL_W-1:CNT_W];
		cnt    = rdata_q[CNT_W-1:0];
		t33    = {2'b00, ts_q};
		st33   = {stored[CNT_W-1], stored};
		if (fwd_q) begin
			has      = !stored[CNT_W-1] && (stored != '0);
			gap      = t33 - st33;
			new_last = CNT_W'(0) - {1'b0, ts_q};
		end else begin
			has      = stored[CNT_W-1];
			gap      = t33 + st33;
			new_last = {1'b0, ts_q};
		end
		take = has && !gap[32] && (gap != '0) && (gap <= {2'b00, gap_timeout_q});
		if (!take)
			new_cnt = cnt;
		else if (add_q)
			new_cnt = cnt + gap[CNT_W-1:0];
		else
			new_cnt = cnt - gap[CNT_W-1:0];
		qval = add_q ? cnt : (CNT_W'(0) - cnt);
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_WRITE && req_q == REQ_INSERT) begin
			mem_we    = 1'b1;
			mem_waddr = mem_raddr;
			mem_wdata = {new_last, new_cnt};
		end
	end

	// Rank of the candidate among the row values (ties broken by row)
	logic [RW:0] rank;
	always_comb begin
		rank = '0;
		for (int j = 0; j < ROWS; j++) begin
			if ($signed(vals_q[j]) < $signed(vals_q[med_i_q]) ||
			    (vals_q[j] == vals_q[med_i_q] && RW'(j) < med_i_q))
				rank = rank + 1'b1;
		end
	end

	// Request capture, hash pipeline, column remainder, row values and median pick
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.req_type;
			key_q <= req.flow_key;
			fwd_q <= req.forward_dir;
			ts_q  <= req.timestamp;
		end
		unique case (state_q)
			ST_KEY1: k_q <= key_q * MM_C1;
			ST_KEY2: k_q <= rotl15(k_q) * MM_C2;
			ST_ROW1: begin
				hi_q <= mm_head(index_seed_q[sel_q] + 32'(off_q), k_q);
				hs_q <= mm_head(sign_seed_q[sel_q] + 32'(off_q), k_q);
			end
			ST_ROW2: begin
				hi_q <= (hi_q ^ (hi_q >> 16)) * MM_C3;
				hs_q <= (hs_q ^ (hs_q >> 16)) * MM_C3;
			end
			ST_ROW3: begin
				hi_q <= (hi_q ^ (hi_q >> 13)) * MM_C4;
				hs_q <= (hs_q ^ (hs_q >> 13)) * MM_C4;
			end
			ST_ROW4: begin
				hi_q  <= hi_q ^ (hi_q >> 16);
				add_q <= hs_q[0] ^ hs_q[16];
			end
			ST_MOD1: quo_q <= mod_prod[63:32];
			// partial remainder, below 2*COLUMNS
			ST_MOD2: hi_q <= hi_q - quo_q * 32'(COLUMNS);
			ST_MOD3: rem_q <= (hi_q >= 32'(COLUMNS)) ? CW'(hi_q - 32'(COLUMNS)) : CW'(hi_q);
			ST_WRITE: vals_q[row_q] <= qval;
			ST_MED: if (rank == (RW+1)'(ROWS / 2)) med_q <= vals_q[med_i_q];
			default: ;
		endcase
	end

	// Control state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			row_q       <= '0;
			sel_q       <= '0;
			off_q       <= '0;
			base_q      <= '0;
			med_i_q     <= '0;
			res_valid_q <= 1'b0;
			res_est_q   <= '0;
		end else begin
			if (res_valid_q && res.ready && state_q != ST_OUT)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CELLS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					row_q  <= '0;
					sel_q  <= '0;
					off_q  <= '0;
					base_q <= '0;
					if (accept)
						state_q <= ST_KEY1;
				end
				ST_KEY1: state_q <= ST_KEY2;
				ST_KEY2: state_q <= ST_ROW1;
				ST_ROW1: state_q <= ST_ROW2;
				ST_ROW2: state_q <= ST_ROW3;
				ST_ROW3: state_q <= ST_ROW4;
				ST_ROW4: state_q <= ST_MOD1;
				ST_MOD1: state_q <= ST_MOD2;
				ST_MOD2: state_q <= ST_MOD3;
				ST_MOD3: state_q <= ST_READ;
				ST_READ: state_q <= ST_WRITE;
				ST_WRITE: begin
					row_q  <= row_q + 1'b1;
					base_q <= base_q + AW'(COLUMNS);
					if (sel_q == 2'(SEED_SETS - 1)) begin
						sel_q <= '0;
						off_q <= off_q + 1'b1;
					end else begin
						sel_q <= sel_q + 1'b1;
					end
					med_i_q <= '0;
					if (!last_row)
						state_q <= ST_ROW1;
					else if (req_q == REQ_INSERT)
						state_q <= ST_IDLE;
					else
						state_q <= ST_MED;
				end
				ST_MED: begin
					med_i_q <= med_i_q + 1'b1;
					if (med_i_q == RW'(ROWS - 1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_est_q   <= med_q[CNT_W-1] ? TS_W'(1) : med_q[TS_W-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`RTT_SK_ASSERT_NXT(a_accept_starts_hash, accept, state_q == ST_KEY1, "accepted request did not start")
	`RTT_SK_ASSERT_IMP(a_write_in_range, mem_we, mem_waddr <= AW'(CELLS - 1), "cell write out of range")
	`RTT_SK_ASSERT_IMP(a_query_no_write, mem_we && state_q != ST_CLEAR, req_q == REQ_INSERT, "query wrote a cell")
	`RTT_SK_ASSERT_IMP(a_result_after_median, $rose(res_valid_q), $past(state_q) == ST_OUT, "result without median")

endmodule

// ===== tb/testbench.sv =====
module testbench;
	import rtt_sk_pkg::*;

	localparam int unsigned NROWS = ROWS_DEF;
	localparam int unsigned NCOLS = COLUMNS_DEF;
	localparam int unsigned NCELLS = NROWS * NCOLS;
	// covers one query, including median ranking and result load
	localparam int unsigned REQ_CYCLES = 4 + 10 * NROWS;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	rtt_sk_req_if req_ch ();
	rtt_sk_res_if res_ch ();

	rtt_sign_sketch DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_ch.sink),
		.res(res_ch.source)
	);

	// sketch shadow state
	logic [30:0] gap_limit;
	logic [31:0] idx_seed [SEED_SETS];
	logic [31:0] sgn_seed [SEED_SETS];
	logic [31:0] rtt_sum [NCELLS];
	logic [31:0] seen_time [NCELLS];

	logic [30:0] estimates_due [$];
	int unsigned fail_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] murmur4(input logic [31:0] key, input logic [31:0] seed);
		logic [31:0] h;
		logic [31:0] k;
		k = key * MM_C1;
		k = rol(k, 15);
		k = k * MM_C2;
		h = seed ^ k;
		h = rol(h, 13);
		h = h * 32'd5 + MM_ADD;
		h = h ^ MM_LEN;
		h = h ^ (h >> 16);
		h = h * MM_C3;
		h = h ^ (h >> 13);
		h = h * MM_C4;
		h = h ^ (h >> 16);
		return h;
	endfunction

	function automatic int unsigned cell_of(input int unsigned r, input logic [31:0] key);
		logic [31:0] hi;
		hi = murmur4(key, idx_seed[r % 3] + 32'(r / 3));
		return r * NCOLS + (hi % NCOLS);
	endfunction

	function automatic bit adds_in(input int unsigned r, input logic [31:0] key);
		logic [31:0] hs;
		hs = murmur4(key, sgn_seed[r % 3] + 32'(r / 3));
		return hs[0];
	endfunction

	// update the shadow sketch; returns 1 and the estimate for a query
	function automatic bit sketch_update(input logic rq, input logic [31:0] key,
			input logic fwd, input logic [30:0] ts, output logic [30:0] est);
		int unsigned c;
		longint stored;
		longint gap;
		longint t;
		int signed v [NROWS];
		int signed tmp;
		t = longint'(ts);
		est = '0;
		if (rq == REQ_INSERT) begin
			for (int unsigned r = 0; r < NROWS; r++) begin
				c = cell_of(r, key);
				stored = longint'($signed(seen_time[c]));
				gap = 0;
				if (fwd) begin
					if (stored > 0) gap = t - stored;
					seen_time[c] = 32'(-t);
				end else begin
					if (stored < 0) gap = t + stored;
					seen_time[c] = 32'(t);
				end
				if (gap > 0 && gap <= longint'(gap_limit)) begin
					if (adds_in(r, key)) rtt_sum[c] = rtt_sum[c] + 32'(gap);
					else rtt_sum[c] = rtt_sum[c] - 32'(gap);
				end
			end
			return 1'b0;
		end
		for (int unsigned r = 0; r < NROWS; r++) begin
			c = cell_of(r, key);
			v[r] = adds_in(r, key) ? $signed(rtt_sum[c]) : $signed(32'd0 - rtt_sum[c]);
		end
		for (int i = 1; i < NROWS; i++)
			for (int j = i; j > 0 && v[j-1] > v[j]; j--) begin
				tmp = v[j];
				v[j] = v[j-1];
				v[j-1] = tmp;
			end
		est = (v[NROWS/2] < 0) ? 31'd1 : v[NROWS/2][30:0];
		return 1'b1;
	endfunction

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GAP_TIMEOUT: gap_limit = val[30:0];
			REG_INDEX_SEED_0: idx_seed[0] = val;
			REG_INDEX_SEED_1: idx_seed[1] = val;
			REG_INDEX_SEED_2: idx_seed[2] = val;
			REG_SIGN_SEED_0: sgn_seed[0] = val;
			REG_SIGN_SEED_1: sgn_seed[1] = val;
			REG_SIGN_SEED_2: sgn_seed[2] = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// one request over the req channel; prediction at acceptance
	task automatic send_request(input logic rq, input logic [31:0] key, input logic fwd,
			input logic [30:0] ts);
		logic [30:0] est;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rq;
		req_ch.flow_key <= key;
		req_ch.forward_dir <= fwd;
		req_ch.timestamp <= ts;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (sketch_update(rq, key, fwd, ts, est)) estimates_due = {estimates_due, est};
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (estimates_due.size() != 0) @(posedge clk);
		repeat (REQ_CYCLES + 10) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (estimates_due.size() == 0) begin
				$display("%0t: unexpected estimate, expected none, actual %0d", $time,
					res_ch.rtt_estimate);
				fail_count++;
			end else begin
				if (res_ch.rtt_estimate !== estimates_due[0]) begin
					$display("%0t: rtt_estimate mismatch, expected %0d, actual %0d", $time,
						estimates_due[0], res_ch.rtt_estimate);
					fail_count++;
				end
				void'(estimates_due.pop_front());
			end
		end
		res_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// a few keys reused so cells collide and pairs form
	function automatic logic [31:0] pick_key();
		return ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(15)) * 32'h9e3779b9;
	endfunction

	task automatic test_directed();
		send_request(REQ_QUERY, 32'd0, 1'b0, 31'd0);
		send_request(REQ_INSERT, 32'd0, 1'b1, 31'd100);
		send_request(REQ_INSERT, 32'd0, 1'b1, 31'd150);
		send_request(REQ_INSERT, 32'd0, 1'b0, 31'd400);
		send_request(REQ_QUERY, 32'd0, 1'b1, 31'h7fffffff);
		send_request(REQ_INSERT, 32'hffffffff, 1'b0, 31'd10);
		send_request(REQ_INSERT, 32'hffffffff, 1'b0, 31'd20);
		send_request(REQ_INSERT, 32'hffffffff, 1'b1, 31'd900);
		send_request(REQ_QUERY, 32'hffffffff, 1'b0, 31'd0);
		send_request(REQ_INSERT, 32'h12345678, 1'b1, 31'd0);
		send_request(REQ_INSERT, 32'h12345678, 1'b0, 31'd50);
		send_request(REQ_INSERT, 32'h12345678, 1'b1, 31'h7fffffff);
		send_request(REQ_INSERT, 32'h12345678, 1'b0, 31'h7fffffff);
		send_request(REQ_INSERT, 32'h12345678, 1'b1, 31'd5);
		send_request(REQ_INSERT, 32'h12345678, 1'b0, 31'd2000000);
		send_request(REQ_QUERY, 32'h12345678, 1'b0, 31'd0);
		send_request(REQ_INSERT, 32'haaaa5555, 1'b1, 31'd1);
		send_request(REQ_INSERT, 32'haaaa5555, 1'b0, 31'd1);
		send_request(REQ_QUERY, 32'haaaa5555, 1'b1, 31'd0);
		drain();
	endtask

	// flow pairs: one direction then the other within a random gap, plus queries and noise
	task automatic test_random(input int unsigned n, input int unsigned max_gap);
		logic [31:0] key;
		logic [30:0] ts;
		logic fwd;
		for (int unsigned i = 0; i < n; i++) begin
			key = pick_key();
			ts = 31'($urandom_range(32'h7fffffff, 1));
			fwd = 1'($urandom_range(1));
			case ($urandom_range(9))
				0, 1, 2: send_request(REQ_QUERY, key, fwd, 31'($urandom));
				3: send_request(REQ_INSERT, $urandom, fwd, 31'($urandom));
				default: begin
					send_request(REQ_INSERT, key, fwd, ts);
					send_request(REQ_INSERT, key, !fwd, ts + 31'($urandom_range(max_gap)));
				end
			endcase
		end
		drain();
	endtask

	task automatic test_idle_mix();
		send_idle_pct = 47; recv_stall_pct = 0;
		test_random(110, 2000);
		send_idle_pct = 0; recv_stall_pct = 47;
		test_random(110, 2000);
		send_idle_pct = 21; recv_stall_pct = 21;
		test_random(110, 2000);
		send_idle_pct = 0; recv_stall_pct = 0;
	endtask

	task automatic test_config_sweep();
		reg_write(REG_GAP_TIMEOUT, 32'h7fffffff);
		reg_write(REG_INDEX_SEED_0, 32'hffffffff);
		reg_write(REG_SIGN_SEED_1, 32'd0);
		test_random(110, 32'h7fffffff);
		reg_write(REG_GAP_TIMEOUT, 32'd0);
		reg_write(REG_INDEX_SEED_1, 32'd0);
		reg_write(REG_SIGN_SEED_2, 32'hffffffff);
		test_random(60, 100);
		reg_write(REG_GAP_TIMEOUT, 32'd500);
		for (int r = 0; r < 3; r++) begin
			reg_write(reg_idx_t'(REG_INDEX_SEED_0 + r), $urandom);
			reg_write(reg_idx_t'(REG_SIGN_SEED_0 + r), $urandom);
		end
		reg_write(REG_INDEX_SEED_2, $urandom);
		reg_write(REG_SIGN_SEED_0, $urandom);
		send_idle_pct = 21; recv_stall_pct = 21;
		test_random(150, 1000);
	endtask

	initial begin
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		gap_limit = GAP_TIMEOUT_RST;
		idx_seed = INDEX_SEED_RST;
		sgn_seed = SIGN_SEED_RST;
		for (int i = 0; i < NCELLS; i++) begin
			rtt_sum[i] = '0;
			seen_time[i] = '0;
		end
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_INSERT;
		req_ch.flow_key = '0;
		req_ch.forward_dir = 1'b0;
		req_ch.timestamp = '0;
		res_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(420, 2000);
		test_idle_mix();
		test_config_sweep();
		if (fail_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	// watchdog: sweep and ~1750 requests with stalls
	initial begin
		#20000000;
		$display("testbench failed");
		$finish;
	end

endmodule

// ===== rtt_sign_sketch.f =====
+incdir+sv
sv/rtt_sk_pkg.sv
sv/rtt_sk_if.sv
sv/rtt_sign_sketch.sv
tb/testbench.sv
